// ===== design/interpolating_delay_history_top_defines.svh =====
// Assertion macros shared by the checker of the delay history block.
`ifndef INTERPOLATING_DELAY_HISTORY_TOP_DEFINES_SVH
`define INTERPOLATING_DELAY_HISTORY_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define IDH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define IDH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/idh_pkg.sv =====
// Package with the types and constants of the interpolating delay history block.
`default_nettype none
package idh_pkg;

    localparam int TIME_W     = 48;
    localparam int SAMPLE_W   = 32;
    localparam int CH_W       = 3;
    localparam int DELAY_W    = 22;
    localparam int RLEN_W     = 7;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 1'b1;

    localparam logic [RLEN_W-1:0] RING_LEN_MIN   = 7'd3;
    localparam logic [RLEN_W-1:0] RING_LEN_RESET = 7'd64;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [TIME_W-1:0]          time_req;
        logic [CH_W-1:0]            channel;
        logic [DELAY_W-1:0]         delay;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] delayed_value;
        logic [CH_W-1:0]            channel_echo;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVP,
        ST_DIVN,
        ST_RDX,
        ST_WAITX,
        ST_DIVQ,
        ST_WRITE,
        ST_RD0,
        ST_RD1,
        ST_CAPY1,
        ST_MUL,
        ST_SUM,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        DIV_PTR,
        DIV_MOD,
        DIV_QUO
    } t_div_sel;

    typedef enum logic {
        RD_SLOT0,
        RD_SLOT1
    } t_rd_sel;

    typedef struct packed {
        logic     clear_en;
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     latch_p;
        logic     latch_mod;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     cap_y0;
        logic     cap_y1;
        logic     mul_en;
        logic     sum_en;
        logic     wr_en;
        logic     commit;
        logic     out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic div_done;
        logic is_store;
        logic ch_ok;
        logic e_pos;
        logic out_free;
        logic clear_last;
    } t_ctl_status;

endpackage
`default_nettype wire

// ===== design/idh_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module idh_div #(
    parameter int NW = 49,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic      [NW-1:0] o_quotient,
    output logic      [DW-1:0] o_remainder,
    output logic               o_done
);
    localparam int CNTW = $clog2(NW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_dvs, n_dvs;

    logic [DW:0] trial;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        ge    = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[NW-2:0], ge};
            n_rem = ge ? DW'(trial - {1'b0, r_dvs}) : trial[DW-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNTW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;
endmodule
`default_nettype wire

// ===== design/idh_datapath.sv =====
// Datapath with the history memory, grid registers, divider and interpolator.
`default_nettype none
module idh_datapath import idh_pkg::*; #(
    parameter int CHANNELS       = 8,
    parameter int CHANNEL_DEPTH  = 64,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_item,
    output t_out_item                  o_out_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_ctl_cmd              i_cmd,
    output t_ctl_status                o_status
);
    localparam int F    = TIME_FRAC_BITS;
    localparam int AW   = $clog2(CHANNEL_DEPTH);
    localparam int LW   = $clog2(CHANNEL_DEPTH + 1);
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MD   = CHANNELS * (2 ** AW);
    localparam int MAW  = $clog2(MD);
    localparam int DW   = (F > LW) ? F : LW;
    localparam int DVW  = ((33 + F) > (51 - F)) ? (33 + F) : (51 - F);
    localparam int PW   = 34 + F;
    localparam int QW   = 34 + LW;
    localparam int SW   = 36 + LW;

    logic [RLEN_W-1:0]        r_ring_len;
    logic [TIME_W-1:0]        r_grid;
    logic [AW-1:0]            r_wp;
    logic [MAW-1:0]           r_clr;
    t_in_item                 r_in;
    logic [AW-1:0]            r_p;
    logic [AW-1:0]            r_slot0;
    logic [AW-1:0]            r_slot1;
    logic signed [31:0]       r_rd_data;
    logic signed [31:0]       r_y0;
    logic signed [31:0]       r_y1;
    logic signed [PW-1:0]     r_prod;
    logic signed [QW-1:0]     r_dq;
    logic signed [31:0]       r_sum;
    t_out_item                r_out;
    logic                     r_out_valid;
    logic signed [31:0]       r_mem [0:MD-1];

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [LW-1:0] len;
    always_comb begin
        if (r_ring_len < RING_LEN_MIN) begin
            len = LW'(RING_LEN_MIN);
        end else if (32'(r_ring_len) > CHANNEL_DEPTH) begin
            len = LW'(CHANNEL_DEPTH);
        end else begin
            len = LW'(r_ring_len);
        end
    end

    logic              ch_ok;
    logic [CHW-1:0]    ch_idx;
    logic              is_store;
    assign ch_ok    = 32'(r_in.channel) < CHANNELS;
    assign ch_idx   = CHW'(r_in.channel);
    assign is_store = r_in.mode == MODE_STORE;

    // Store: whole grid steps elapsed and the leftover fraction.
    logic              t_ge;
    logic [TIME_W-1:0] gdiff;
    logic [TIME_W-1:0] n_steps;
    logic [TIME_W-1:0] g_new;
    logic [F-1:0]      e_frac;
    logic              e_pos;
    always_comb begin
        t_ge    = r_in.time_req >= r_grid;
        gdiff   = r_in.time_req - r_grid;
        n_steps = t_ge ? (gdiff >> F) : '0;
        g_new   = t_ge ? (r_grid + {gdiff[TIME_W-1:F], {F{1'b0}}}) : r_grid;
        e_frac  = gdiff[F-1:0];
        e_pos   = t_ge && (e_frac != '0);
    end

    // Query: distance from the grid point in whole and fractional steps.
    logic signed [49:0] d_q;
    logic signed [49:0] fl;
    logic signed [50:0] kx;
    logic signed [50:0] kadj;
    logic        [50:0] kabs;
    logic               kneg;
    logic [F-1:0]       rfrac;
    always_comb begin
        d_q   = $signed({2'b00, r_in.time_req}) - $signed({28'd0, r_in.delay})
              - $signed({2'b00, r_grid});
        fl    = d_q >>> F;
        kx    = -(51'(fl));
        kneg  = kx[50];
        kadj  = kneg ? (kx + $signed(51'(len))) : kx;
        kabs  = kadj[50] ? 51'(-kadj) : 51'(kadj);
        rfrac = d_q[F-1:0];
    end

    // Store: extrapolation numerator.
    logic signed [32:0] sd;
    logic        [32:0] sabs;
    always_comb begin
        sd   = 33'(r_in.sample) - 33'(r_rd_data);
        sabs = sd[32] ? 33'(-sd) : 33'(sd);
    end

    logic [DVW-1:0] div_num;
    logic [DW-1:0]  div_den;
    logic [DVW-1:0] div_quo;
    logic [DW-1:0]  div_rem;
    logic           div_done;
    always_comb begin
        case (i_cmd.div_sel)
            DIV_PTR: begin
                div_num = DVW'(r_wp);
                div_den = DW'(len);
            end
            DIV_MOD: begin
                div_num = is_store ? DVW'(n_steps) : DVW'(kabs);
                div_den = DW'(len);
            end
            DIV_QUO: begin
                div_num = DVW'({sabs, {F{1'b0}}});
                div_den = DW'(e_frac);
            end
            default: begin
                div_num = '0;
                div_den = DW'(len);
            end
        endcase
    end

    idh_div #(
        .NW(DVW),
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (div_quo),
        .o_remainder(div_rem),
        .o_done     (div_done)
    );

    // Ring slot arithmetic after the modulo pass.
    logic [LW-1:0] rmod;
    logic [LW:0]   km;
    logic [LW:0]   jm;
    logic [LW:0]   pe;
    logic [LW:0]   pnew;
    logic [LW:0]   i1;
    logic [LW:0]   s0;
    logic [LW:0]   s1;
    logic [LW:0]   lenx;
    always_comb begin
        lenx = (LW+1)'(len);
        rmod = LW'(div_rem);
        pe   = (LW+1)'(r_p);
        km   = (kadj[50] && (rmod != '0)) ? (lenx - (LW+1)'(rmod)) : (LW+1)'(rmod);
        jm   = (km == '0) ? (lenx - 1'b1) : (km - 1'b1);
        if (pe >= (LW+1)'(rmod)) begin
            pnew = pe - (LW+1)'(rmod);
        end else begin
            pnew = pe + lenx - (LW+1)'(rmod);
        end
        i1 = (pnew == '0) ? (lenx - 1'b1) : (pnew - 1'b1);
        s0 = pe + km;
        if (s0 >= lenx) begin
            s0 = s0 - lenx;
        end
        s1 = pe + jm;
        if (s1 >= lenx) begin
            s1 = s1 - lenx;
        end
    end

    // Store: extrapolated value with floor rounding.
    logic              rem_nz;
    logic [DVW:0]      qmag;
    logic signed [DVW:0]   qsg;
    logic signed [DVW+1:0] vq;
    logic signed [31:0]    vq_sat;
    always_comb begin
        rem_nz = div_rem != '0;
        qmag   = {1'b0, div_quo} + {{DVW{1'b0}}, rem_nz};
        qsg    = sd[32] ? -$signed(qmag) : $signed({1'b0, div_quo});
        vq     = (DVW+2)'(r_rd_data) + (DVW+2)'(qsg);
        vq_sat = sat32(64'(vq));
    end

    // Query: interpolation terms.
    logic signed [32:0]   ydiff;
    logic signed [SW-1:0] vs;
    always_comb begin
        ydiff = 33'(r_y1) - 33'(r_y0);
        vs    = SW'(r_y0) + SW'(r_dq) + SW'(r_prod >>> F);
    end

    logic [MAW-1:0]     rd_addr;
    logic [MAW-1:0]     wr_addr;
    logic               mem_we;
    logic signed [31:0] wr_data;
    logic [AW-1:0]      st_slot;
    logic [CHW+AW-1:0]  rd_full;
    logic [CHW+AW-1:0]  wr_full;
    always_comb begin
        rd_full = {ch_idx, (i_cmd.rd_sel == RD_SLOT1) ? r_slot1 : r_slot0};
        rd_addr = rd_full[MAW-1:0];
        st_slot = e_pos ? r_slot1 : r_slot0;
        wr_full = {ch_idx, st_slot};
        mem_we  = i_cmd.clear_en || (i_cmd.wr_en && ch_ok);
        wr_addr = i_cmd.clear_en ? r_clr : wr_full[MAW-1:0];
        if (i_cmd.clear_en) begin
            wr_data = '0;
        end else if (e_pos) begin
            wr_data = vq_sat;
        end else begin
            wr_data = r_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_len  <= RING_LEN_RESET;
            r_grid      <= '0;
            r_wp        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we && (i_cfg_idx == REG_START_TIME)) begin
                r_grid <= i_cfg_data[TIME_W-1:0];
            end else if (i_cmd.commit) begin
                r_grid <= g_new;
            end
            if (i_cmd.commit) begin
                r_wp <= r_slot0;
            end
            if (i_cfg_we && (i_cfg_idx == REG_RING_LENGTH)) begin
                r_ring_len <= i_cfg_data[RLEN_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.latch_p) begin
            r_p <= AW'(div_rem);
        end
        if (i_cmd.latch_mod) begin
            r_slot0 <= is_store ? AW'(pnew) : AW'(s0);
            r_slot1 <= is_store ? AW'(i1) : AW'(s1);
        end
        if (i_cmd.cap_y0) begin
            r_y0 <= r_rd_data;
        end
        if (i_cmd.cap_y1) begin
            r_y1 <= r_rd_data;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PW'(ydiff) * PW'($signed({1'b0, rfrac}));
            r_dq   <= kneg ? (QW'(ydiff) * QW'($signed({1'b0, len}))) : '0;
        end
        if (i_cmd.sum_en) begin
            r_sum <= sat32(64'(vs));
        end
        if (i_cmd.out_load) begin
            r_out.delayed_value <= ch_ok ? r_sum : '0;
            r_out.channel_echo  <= r_in.channel;
        end
    end

    always_comb begin
        o_status.div_done   = div_done;
        o_status.is_store   = is_store;
        o_status.ch_ok      = ch_ok;
        o_status.e_pos      = e_pos;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.clear_last = r_clr == MAW'(MD - 1);
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== design/idh_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
`default_nettype none
module idh_ctrl import idh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_ctl_status i_status,
    output t_ctl_cmd         o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clear_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_DIVP;
            ST_DIVP:   if (i_status.div_done) n_state = ST_DIVN;
            ST_DIVN: begin
                if (i_status.div_done) begin
                    if (i_status.is_store) begin
                        n_state = i_status.ch_ok ? ST_RDX : ST_WRITE;
                    end else begin
                        n_state = i_status.ch_ok ? ST_RD0 : ST_RESULT;
                    end
                end
            end
            ST_RDX:    n_state = ST_WAITX;
            ST_WAITX:  n_state = i_status.e_pos ? ST_DIVQ : ST_WRITE;
            ST_DIVQ:   if (i_status.div_done) n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            ST_RD0:    n_state = ST_RD1;
            ST_RD1:    n_state = ST_CAPY1;
            ST_CAPY1:  n_state = ST_MUL;
            ST_MUL:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_RESULT;
            ST_RESULT: if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.div_sel = DIV_PTR;
        o_cmd.rd_sel  = RD_SLOT0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clear_en = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_PTR;
                end
            end
            ST_DIVP: begin
                if (i_status.div_done) begin
                    o_cmd.latch_p   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MOD;
                end
            end
            ST_DIVN: begin
                o_cmd.div_sel = DIV_MOD;
                if (i_status.div_done) o_cmd.latch_mod = 1'b1;
            end
            ST_RDX: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SLOT0;
            end
            ST_WAITX: begin
                o_cmd.div_sel = DIV_QUO;
                if (i_status.e_pos) o_cmd.div_start = 1'b1;
            end
            ST_DIVQ: o_cmd.div_sel = DIV_QUO;
            ST_WRITE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.commit = 1'b1;
            end
            ST_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SLOT0;
            end
            ST_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SLOT1;
                o_cmd.cap_y0 = 1'b1;
            end
            ST_CAPY1:  o_cmd.cap_y1 = 1'b1;
            ST_MUL:    o_cmd.mul_en = 1'b1;
            ST_SUM:    o_cmd.sum_en = 1'b1;
            ST_RESULT: if (i_status.out_free) o_cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== design/interpolating_delay_history_top.sv =====
// Top level of the multichannel interpolating delay history.
// The input channel takes one item per handshake: a store writes a channel's
// sample at a time on the grid, a query returns the linearly interpolated
// value of a channel at time minus delay. Each query gives one result item
// on the output channel; a store gives none.
// Items are worked on one at a time. A serial divider that yields one bit
// per cycle divides a W-bit dividend, with W = max(33 + TIME_FRAC_BITS,
// 51 - TIME_FRAC_BITS) (49 by default): a query runs two divisions, and a
// store two, or three when it extrapolates. The next item is accepted only
// once the current one has finished.
// Configuration is a plain write port taken at any cycle; writing start_time
// reloads the grid time.
// After reset the history memory is cleared one entry a cycle, all
// CHANNELS * 2**clog2(CHANNEL_DEPTH) entries (512 by default); no item is
// accepted until it ends. A finished result waits in the output register
// while the receiver stalls, and the next item is accepted meanwhile.
`default_nettype none
module interpolating_delay_history_top import idh_pkg::*; #(
    parameter int CHANNELS       = 8,
    parameter int CHANNEL_DEPTH  = 64,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_ctl_cmd    cmd;
    t_ctl_status status;

    idh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    idh_datapath #(
        .CHANNELS      (CHANNELS),
        .CHANNEL_DEPTH (CHANNEL_DEPTH),
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status)
    );
endmodule
`default_nettype wire

// ===== design/idh_checker.sv =====
// Port checker for the interpolating delay history and its bind statement.
`default_nettype none
`include "interpolating_delay_history_top_defines.svh"
module idh_checker import idh_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);
    `IDH_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "Stalled result item changed or dropped.")
    `IDH_ASSERT(a_one_at_a_time, i_in_valid && o_in_ready |=> !o_in_ready, "Input accepted while an item is still in progress.")
    `IDH_ASSERT(a_no_instant_result, i_in_valid && o_in_ready |=> !$rose(o_out_valid), "Result item appeared in the cycle after acceptance.")
    `IDH_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_in_ready && !o_out_valid, "Block not quiet after reset.")
endmodule

bind interpolating_delay_history_top idh_checker u_idh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the interpolating delay history block.
`default_nettype none
module tb import idh_pkg::*; ();

    localparam longint GRID_STEP = 64'sd65536;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int          hist_mem [8][64];
    logic [47:0] grid_now;
    longint      wr_ptr;
    logic [6:0]  ring_len_reg;
    t_out_item   pending_q[$];
    int          fail_count = 0;
    bit          stall_on = 1'b1;

    interpolating_delay_history_top dut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= stall_on ? ($urandom_range(99) >= 18) : 1'b1;
    end

    function automatic longint ring_wrap(longint v, longint l);
        longint r;
        r = v % l;
        if (r < 0) r += l;
        return r;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic predict_item(t_in_item it);
        longint l, p, g, t, n, e, i0, i1, x0, s, q, d, k, j, y0, y1, dx, diff, r;
        t_out_item res;
        l = ring_len_reg < 3 ? 3 : (ring_len_reg > 64 ? 64 : ring_len_reg);
        p = ring_wrap(wr_ptr, l);
        g = {16'd0, grid_now};
        t = {16'd0, it.time_req};
        if (it.mode == MODE_STORE) begin
            n = 0;
            if (t >= g) n = (t - g) >>> 16;
            g += n * GRID_STEP;
            grid_now = g[47:0];
            p = ring_wrap(p - ring_wrap(n, l), l);
            wr_ptr = p;
            i0 = p;
            i1 = i0 != 0 ? i0 - 1 : l - 1;
            x0 = hist_mem[it.channel][i0];
            s = it.sample;
            e = t - g;
            if (e > 0) begin
                q = ((s - x0) * GRID_STEP) / e;
                if ((((s - x0) * GRID_STEP) % e) != 0 && (s - x0) < 0) q -= 1;
                hist_mem[it.channel][i1] = int'(sat_word(x0 + q));
            end else begin
                hist_mem[it.channel][i0] = it.sample;
            end
        end else begin
            d = (t - longint'({42'd0, it.delay})) - g;
            k = -(d >>> 16);
            if (k < 0) k += l;
            j = k != 0 ? k - 1 : l - 1;
            y0 = hist_mem[it.channel][ring_wrap(p + ring_wrap(k, l), l)];
            y1 = hist_mem[it.channel][ring_wrap(p + ring_wrap(j, l), l)];
            dx = d + k * GRID_STEP;
            diff = y1 - y0;
            q = dx >>> 16;
            r = dx - q * GRID_STEP;
            res.delayed_value = 32'(sat_word(y0 + diff * q + ((diff * r) >>> 16)));
            res.channel_echo = it.channel;
            pending_q.push_back(res);
        end
    endtask

    task automatic send_item(t_in_item it);
        if (stall_on) begin
            while ($urandom_range(99) < 18) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_in_item = it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(it);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_RING_LENGTH) begin
            ring_len_reg = val[6:0];
        end else begin
            grid_now = val;
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(bit mode, logic [47:0] tr, logic [2:0] ch,
                                           logic [21:0] dl, logic [31:0] smp);
        t_in_item it;
        it.mode = mode;
        it.time_req = tr;
        it.channel = ch;
        it.delay = dl;
        it.sample = smp;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t unexpected item value %0d channel %0d", $time,
                         o_out_item.delayed_value, o_out_item.channel_echo);
                fail_count++;
            end else begin
                if (o_out_item.delayed_value !== pending_q[0].delayed_value) begin
                    $display("%0t value mismatch expected %0d actual %0d", $time,
                             pending_q[0].delayed_value, o_out_item.delayed_value);
                    fail_count++;
                end
                if (o_out_item.channel_echo !== pending_q[0].channel_echo) begin
                    $display("%0t channel mismatch expected %0d actual %0d", $time,
                             pending_q[0].channel_echo, o_out_item.channel_echo);
                    fail_count++;
                end
                void'(pending_q.pop_front());
            end
        end
    end

    task automatic test_directed();
        logic [47:0] g;
        write_reg(REG_RING_LENGTH, 48'd64);
        write_reg(REG_START_TIME, 48'd0);
        send_item(make_item(MODE_QUERY, 48'd0, 3'd0, 22'd0, 32'd0));
        send_item(make_item(MODE_STORE, 48'd0, 3'd0, 22'd0, 32'h7FFFFFFF));
        send_item(make_item(MODE_STORE, 48'h10000, 3'd0, 22'd0, 32'h80000000));
        send_item(make_item(MODE_STORE, 48'h20001, 3'd1, 22'd0, 32'h7FFFFFFF));
        send_item(make_item(MODE_STORE, 48'h30001, 3'd1, 22'd0, 32'h80000000));
        send_item(make_item(MODE_QUERY, 48'h30000, 3'd0, 22'h18000, 32'd0));
        send_item(make_item(MODE_QUERY, 48'h30000, 3'd1, 22'd4063232, 32'd0));
        send_item(make_item(MODE_QUERY, 48'hFFFFFFFFFFFF, 3'd7, 22'd0, 32'hFFFFFFFF));
        send_item(make_item(MODE_STORE, 48'h8000, 3'd7, 22'h3FFFFF, 32'h12345678));
        send_item(make_item(MODE_QUERY, 48'h30000, 3'd1, 22'h8000, 32'd0));
        wait_idle();
        write_reg(REG_RING_LENGTH, 48'd0);
        write_reg(REG_START_TIME, 48'hFFFFFFFF0000);
        send_item(make_item(MODE_STORE, 48'hFFFFFFFFFFFF, 3'd2, 22'd0, 32'd1000));
        send_item(make_item(MODE_STORE, 48'hFFFFFFFF0001, 3'd2, 22'd0, 32'h40000000));
        send_item(make_item(MODE_QUERY, 48'hFFFFFFFFFFFF, 3'd2, 22'h30000, 32'd0));
        send_item(make_item(MODE_QUERY, 48'h0, 3'd2, 22'h0, 32'd0));
        wait_idle();
        write_reg(REG_RING_LENGTH, 48'd127);
        write_reg(REG_START_TIME, 48'd0);
        g = 48'd0;
        for (int i = 0; i < 6; i++) begin
            g += 48'h10000;
            send_item(make_item(MODE_STORE, g, 3'd5, 22'd0, $urandom));
        end
        send_item(make_item(MODE_QUERY, g, 3'd5, 22'h28000, 32'd0));
        wait_idle();
        write_reg(REG_RING_LENGTH, 48'd3);
        send_item(make_item(MODE_QUERY, g, 3'd5, 22'h10000, 32'd0));
        send_item(make_item(MODE_QUERY, g + 48'h123, 3'd5, 22'h3E0000, 32'd0));
        wait_idle();
    endtask

    task automatic test_random(int count);
        t_in_item it;
        longint span;
        for (int i = 0; i < count; i++) begin
            span = ring_len_reg < 3 ? 3 : (ring_len_reg > 64 ? 64 : ring_len_reg);
            if ($urandom_range(99) < 80) begin
                it.channel = 3'($urandom_range(7));
                it.sample = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000) - 100000;
                if ($urandom_range(1)) begin
                    it.mode = MODE_STORE;
                    it.time_req = grid_now + 48'($urandom_range(3) * 65536)
                                + 48'(($urandom_range(3) == 0) ? 0 : $urandom_range(65535));
                    it.delay = 22'($urandom);
                end else begin
                    it.mode = MODE_QUERY;
                    it.time_req = grid_now + 48'($urandom_range(65535));
                    it.delay = 22'($urandom_range(int'(span) * 65536 + 65536));
                end
            end else begin
                it.mode = 1'($urandom_range(1));
                it.time_req = 48'({$urandom, $urandom});
                it.channel = 3'($urandom_range(7));
                it.delay = 22'($urandom_range(4063232));
                it.sample = $urandom;
            end
            send_item(it);
        end
    endtask

    task automatic test_settings();
        for (int ph = 0; ph < 6; ph++) begin
            stall_on = (ph != 2);
            case (ph)
                0: begin
                    write_reg(REG_RING_LENGTH, 48'd3);
                    write_reg(REG_START_TIME, 48'd0);
                end
                1: begin
                    write_reg(REG_RING_LENGTH, 48'd64);
                    write_reg(REG_START_TIME, 48'hFFFFFFFFFFFF);
                end
                default: begin
                    write_reg(REG_RING_LENGTH, 48'($urandom_range(127)));
                    write_reg(REG_START_TIME, 48'({$urandom, $urandom}) & 48'h7FFFFFFFFFFF);
                end
            endcase
            test_random(270);
            wait_idle();
        end
        stall_on = 1'b1;
    endtask

    initial begin
        for (int c = 0; c < 8; c++)
            for (int s = 0; s < 64; s++) hist_mem[c][s] = 0;
        grid_now = '0;
        wr_ptr = 0;
        ring_len_reg = 7'd64;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_settings();
        wait_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
